// ----- rtl/core/brf_pkg.sv -----
package brf_pkg;

  localparam int DATA_WIDTH = 32;

  localparam int REG_COUNT  = 16;
  localparam int FIQ_COUNT  = 7;
  localparam int PRIV_COUNT = 8;
  localparam int PHYS_COUNT = REG_COUNT + FIQ_COUNT + PRIV_COUNT;
  localparam int PHYS_W     = $clog2(PHYS_COUNT);
  localparam int FIQ_BASE   = REG_COUNT;
  localparam int PRIV_BASE  = REG_COUNT + FIQ_COUNT;

  localparam logic [3:0] MODE_MASK  = 4'hF;
  localparam logic [3:0] MODE_COUNT = 4'd6;

  typedef enum logic [1:0] {
    FUNC_SET_MODE  = 2'd0,
    FUNC_READ_CUR  = 2'd1,
    FUNC_READ_USR  = 2'd2,
    FUNC_WRITE_CUR = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    MODE_USR = 3'd0,
    MODE_FIQ = 3'd1,
    MODE_SVC = 3'd2,
    MODE_ABT = 3'd3,
    MODE_IRQ = 3'd4,
    MODE_UND = 3'd5
  } mode_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  reg_index;
    logic [7:0]  mode_value;
    logic [31:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        error;
  } out_item_t;

  typedef struct packed {
    logic              mode_wr;
    logic [2:0]        new_mode;
    logic              wr_en;
    logic              rd_en;
    logic [PHYS_W-1:0] phys;
    logic              error;
  } brf_ctrl_t;

endpackage

// ----- rtl/core/banked_register_file.sv -----
// Banked register file with six processor modes: user, fiq, svc, abt, irq and
// und. Each command on in_data sets the mode, reads a register in the current
// or the user view, or writes a register in the current view, and gives exactly
// one result on out_data, marked by out_valid, via input and output registers.
// busy is never raised, so a command can be issued every cycle; commands take
// effect in order, and a read sees every earlier write and mode change. The
// result appears for one cycle only and cannot be held off by the receiver.
// Register numbers above 15 or modes above 5 in the low nibble return error with
// zero data and leave all state unchanged. Registers and the mode reset to zero.
module banked_register_file (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  brf_pkg::in_item_t   in_data,
  output logic                out_valid,
  output brf_pkg::out_item_t  out_data
);
  import brf_pkg::*;

  logic                  in_valid_r;
  in_item_t              in_r;
  logic                  out_valid_r;
  out_item_t             out_r;
  out_item_t             out_nxt;
  brf_ctrl_t             ctrl;
  logic [DATA_WIDTH-1:0] rdata;
  logic [2:0]            cur_mode;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_r <= in_data;
    end
  end

  brf_decode u_decode (
    .valid    (in_valid_r),
    .item     (in_r),
    .cur_mode (cur_mode),
    .ctrl     (ctrl)
  );

  brf_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .wdata    (DATA_WIDTH'(in_r.write_value)),
    .rdata    (rdata),
    .cur_mode (cur_mode)
  );

  always_comb begin
    out_nxt.error     = ctrl.error;
    out_nxt.read_data = ctrl.rd_en ? 32'(rdata) : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/core/brf_decode.sv -----
module brf_decode (
  input  logic              valid,
  input  brf_pkg::in_item_t item,
  input  logic [2:0]        cur_mode,
  output brf_pkg::brf_ctrl_t ctrl
);
  import brf_pkg::*;

  logic [3:0]        mode_low;
  logic [3:0]        r;
  logic              idx_bad;
  logic              mode_bad;
  logic [PHYS_W-1:0] view_phys;
  logic [2:0]        priv_off;

  assign mode_low = item.mode_value[3:0] & MODE_MASK;
  assign r        = item.reg_index[3:0];
  assign idx_bad  = (item.reg_index[7:4] != 4'd0);
  assign mode_bad = (mode_low >= MODE_COUNT);
  assign priv_off = 3'((cur_mode - 3'(MODE_SVC)) * 3'd2 + 3'(r - 4'd13));

  always_comb begin
    view_phys = PHYS_W'(r);
    if (r < 4'd8 || r == 4'd15) begin
      view_phys = PHYS_W'(r);
    end else if (cur_mode == MODE_FIQ) begin
      view_phys = PHYS_W'(FIQ_BASE) + PHYS_W'(r - 4'd8);
    end else if (cur_mode >= MODE_SVC && cur_mode <= MODE_UND && r >= 4'd13) begin
      view_phys = PHYS_W'(PRIV_BASE) + PHYS_W'(priv_off);
    end
  end

  always_comb begin
    ctrl          = '0;
    ctrl.new_mode = mode_low[2:0];
    ctrl.phys     = view_phys;
    unique case (func_t'(item.func))
      FUNC_SET_MODE: begin
        ctrl.error   = mode_bad;
        ctrl.mode_wr = valid && !mode_bad;
      end
      FUNC_READ_CUR: begin
        ctrl.error = idx_bad;
        ctrl.rd_en = !idx_bad;
      end
      FUNC_READ_USR: begin
        ctrl.error = idx_bad;
        ctrl.rd_en = !idx_bad;
        ctrl.phys  = PHYS_W'(r);
      end
      default: begin
        ctrl.error = idx_bad;
        ctrl.wr_en = valid && !idx_bad;
      end
    endcase
  end

endmodule

// ----- rtl/core/brf_regs.sv -----
module brf_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  brf_pkg::brf_ctrl_t               ctrl,
  input  logic [brf_pkg::DATA_WIDTH-1:0]   wdata,
  output logic [brf_pkg::DATA_WIDTH-1:0]   rdata,
  output logic [2:0]                       cur_mode
);
  import brf_pkg::*;

  logic [DATA_WIDTH-1:0] cell_r [PHYS_COUNT];
  logic [2:0]            mode_r;
  logic [2:0]            mode_nxt;

  assign mode_nxt = ctrl.mode_wr ? ctrl.new_mode : mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_USR;
      for (int i = 0; i < PHYS_COUNT; i++) begin
        cell_r[i] <= '0;
      end
    end else begin
      mode_r <= mode_nxt;
      if (ctrl.wr_en) begin
        cell_r[ctrl.phys] <= wdata;
      end
    end
  end

  assign rdata    = cell_r[ctrl.phys];
  assign cur_mode = mode_r;

endmodule

// ----- rtl/core/brf_checker.sv -----
module brf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input brf_pkg::in_item_t  in_data,
  input logic               out_valid,
  input brf_pkg::out_item_t out_data
);
  import brf_pkg::*;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("transfer without result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##2 !out_valid)
    else $error("result without transfer");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.error) |-> (out_data.read_data == 32'd0))
    else $error("error result carries data");

  a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_data.func, 2) == FUNC_WRITE_CUR)
      |-> (out_data.read_data == 32'd0))
    else $error("write result carries data");

endmodule

bind banked_register_file brf_checker u_brf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
